[hw/rtl/hbk_pkg.sv]
// Shared types and constants for the HID boot keyboard report differencer.
package hbk_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int MOD_COUNT = 8;
    localparam int MOD_W = 3;
    localparam int STEP_COUNT = MOD_COUNT + 2 * KEY_SLOTS;
    localparam int STEP_W = $clog2(STEP_COUNT);
    localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int USAGE_W = 8;
    localparam int LEN_W = 13;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [LEN_W-1:0] MIN_REPORT_BYTES = LEN_W'(8);
    localparam logic [USAGE_W-1:0] MOD_BASE = 8'hE0;

    localparam logic [LEN_W-1:0] RESET_REPORT_LENGTH = LEN_W'(8);
    localparam logic [USAGE_W-1:0] RESET_USAGE_MIN = 8'd4;
    localparam logic [USAGE_W-1:0] RESET_USAGE_MAX = 8'd231;

    typedef enum logic [1:0] {
        REG_REPORT_LENGTH = 2'd0,
        REG_USAGE_MIN     = 2'd1,
        REG_USAGE_MAX     = 2'd2
    } reg_idx_t;

    typedef logic [KEY_SLOTS-1:0][USAGE_W-1:0] slots_t;

    typedef struct packed {
        logic               short_report;
        logic [USAGE_W-1:0] usage_min;
        logic [USAGE_W-1:0] usage_max;
    } cfg_t;

    typedef struct packed {
        logic [STEP_W-1:0]  step;
        logic [USAGE_W-1:0] mods_prior;
        logic [USAGE_W-1:0] mods_cur;
        slots_t             keys_prior;
        slots_t             keys_cur;
        logic [USAGE_W-1:0] usage_min;
        logic [USAGE_W-1:0] usage_max;
    } eval_req_t;

    typedef struct packed {
        logic               hit;
        logic [USAGE_W-1:0] usage;
        logic               press;
    } eval_rsp_t;

    typedef struct packed {
        logic              busy;
        logic [STEP_W-1:0] step;
    } status_t;

endpackage

[hw/rtl/hbk_if.sv]
// Handshake channel interfaces for reports and key events.
interface hbk_report_if;
    logic       valid;
    logic       ready;
    logic [7:0] modifier_bits;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;

    modport source (
        output valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
               key_slot_3, key_slot_4, key_slot_5,
        input  ready
    );
    modport sink (
        input  valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
               key_slot_3, key_slot_4, key_slot_5,
        output ready
    );
endinterface

interface hbk_event_if;
    logic       valid;
    logic       ready;
    logic [7:0] usage_code;
    logic       is_press;
    logic       last_event;

    modport source (
        output valid, usage_code, is_press, last_event,
        input  ready
    );
    modport sink (
        input  valid, usage_code, is_press, last_event,
        output ready
    );
endinterface

[hw/rtl/hbk_eval.sv]
// Shared compare unit that decides whether one scan step yields a key event.
module hbk_eval (
    input  hbk_pkg::eval_req_t req,
    output hbk_pkg::eval_rsp_t rsp
);

    function automatic logic slots_hold(
        input hbk_pkg::slots_t                  slots,
        input logic [hbk_pkg::USAGE_W-1:0]      usage
    );
        logic found;
        found = 1'b0;
        for (int i = 0; i < hbk_pkg::KEY_SLOTS; i++)
        begin
            if (slots[i] == usage)
            begin
                found = 1'b1;
            end
        end
        return found && (usage != '0);
    endfunction

    logic [hbk_pkg::STEP_W-1:0]  old_off;
    logic [hbk_pkg::STEP_W-1:0]  new_off;
    logic [hbk_pkg::SLOT_W-1:0]  old_idx;
    logic [hbk_pkg::SLOT_W-1:0]  new_idx;
    logic [hbk_pkg::MOD_W-1:0]   bit_idx;
    logic [hbk_pkg::USAGE_W-1:0] old_u;
    logic [hbk_pkg::USAGE_W-1:0] new_u;
    logic                        old_in_range;
    logic                        new_in_range;

    always_comb
    begin
        old_off = req.step - hbk_pkg::STEP_W'(hbk_pkg::MOD_COUNT);
        new_off = req.step - hbk_pkg::STEP_W'(hbk_pkg::MOD_COUNT + hbk_pkg::KEY_SLOTS);
        old_idx = old_off[hbk_pkg::SLOT_W-1:0];
        new_idx = new_off[hbk_pkg::SLOT_W-1:0];
        bit_idx = req.step[hbk_pkg::MOD_W-1:0];
        old_u = req.keys_prior[old_idx];
        new_u = req.keys_cur[new_idx];
        old_in_range = (old_u >= req.usage_min) && (old_u <= req.usage_max);
        new_in_range = (new_u >= req.usage_min) && (new_u <= req.usage_max);

        if (req.step < hbk_pkg::STEP_W'(hbk_pkg::MOD_COUNT))
        begin
            rsp.hit = req.mods_prior[bit_idx] ^ req.mods_cur[bit_idx];
            rsp.usage = hbk_pkg::MOD_BASE + hbk_pkg::USAGE_W'(bit_idx);
            rsp.press = req.mods_cur[bit_idx];
        end
        else if (req.step < hbk_pkg::STEP_W'(hbk_pkg::MOD_COUNT + hbk_pkg::KEY_SLOTS))
        begin
            rsp.hit = (old_u != '0) && old_in_range && !slots_hold(req.keys_cur, old_u);
            rsp.usage = old_u;
            rsp.press = 1'b0;
        end
        else
        begin
            rsp.hit = (new_u != '0) && new_in_range && !slots_hold(req.keys_prior, new_u);
            rsp.usage = new_u;
            rsp.press = 1'b1;
        end
    end

endmodule

[hw/rtl/hbk_ctrl.sv]
// Sequencer that scans one report, holds the stored report and drives events.
module hbk_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hbk_pkg::cfg_t        cfg,
    hbk_report_if.sink           report,
    hbk_event_if.source          key_event,
    output hbk_pkg::status_t     status
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [hbk_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        held_valid_reg, held_valid_next;
    logic [hbk_pkg::USAGE_W-1:0] held_usage_reg, held_usage_next;
    logic                        held_press_reg, held_press_next;
    logic                        out_valid_reg, out_valid_next;
    logic [hbk_pkg::USAGE_W-1:0] out_usage_reg, out_usage_next;
    logic                        out_press_reg, out_press_next;
    logic                        out_last_reg, out_last_next;
    logic [hbk_pkg::USAGE_W-1:0] prior_mods_reg, prior_mods_next;
    hbk_pkg::slots_t             prior_keys_reg, prior_keys_next;
    logic [hbk_pkg::USAGE_W-1:0] cur_mods_reg, cur_mods_next;
    hbk_pkg::slots_t             cur_keys_reg, cur_keys_next;

    hbk_pkg::eval_req_t          req;
    hbk_pkg::eval_rsp_t          rsp;
    logic                        out_free;
    hbk_pkg::slots_t             in_keys;

    assign in_keys = {report.key_slot_5, report.key_slot_4, report.key_slot_3,
                      report.key_slot_2, report.key_slot_1, report.key_slot_0};

    assign req.step = step_reg;
    assign req.mods_prior = prior_mods_reg;
    assign req.mods_cur = cur_mods_reg;
    assign req.keys_prior = prior_keys_reg;
    assign req.keys_cur = cur_keys_reg;
    assign req.usage_min = cfg.usage_min;
    assign req.usage_max = cfg.usage_max;

    hbk_eval u_eval (
        .req (req),
        .rsp (rsp)
    );

    assign out_free = !out_valid_reg || key_event.ready;

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        held_valid_next = held_valid_reg;
        held_usage_next = held_usage_reg;
        held_press_next = held_press_reg;
        out_valid_next = out_valid_reg && !key_event.ready;
        out_usage_next = out_usage_reg;
        out_press_next = out_press_reg;
        out_last_next = out_last_reg;
        prior_mods_next = prior_mods_reg;
        prior_keys_next = prior_keys_reg;
        cur_mods_next = cur_mods_reg;
        cur_keys_next = cur_keys_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (report.valid && !cfg.short_report)
                begin
                    cur_mods_next = report.modifier_bits;
                    cur_keys_next = in_keys;
                    step_next = '0;
                    held_valid_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!(rsp.hit && held_valid_reg && !out_free))
                begin
                    if (rsp.hit)
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_usage_next = held_usage_reg;
                            out_press_next = held_press_reg;
                            out_last_next = 1'b0;
                        end
                        held_valid_next = 1'b1;
                        held_usage_next = rsp.usage;
                        held_press_next = rsp.press;
                    end
                    if (step_reg == hbk_pkg::STEP_W'(hbk_pkg::STEP_COUNT - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!held_valid_reg || out_free)
                begin
                    if (held_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_usage_next = held_usage_reg;
                        out_press_next = held_press_reg;
                        out_last_next = 1'b1;
                    end
                    held_valid_next = 1'b0;
                    prior_mods_next = cur_mods_reg;
                    prior_keys_next = cur_keys_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            prior_mods_reg <= '0;
            prior_keys_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg <= out_valid_next;
            prior_mods_reg <= prior_mods_next;
            prior_keys_reg <= prior_keys_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_usage_reg <= held_usage_next;
        held_press_reg <= held_press_next;
        out_usage_reg <= out_usage_next;
        out_press_reg <= out_press_next;
        out_last_reg <= out_last_next;
        cur_mods_reg <= cur_mods_next;
        cur_keys_reg <= cur_keys_next;
    end

    assign report.ready = (state_reg == ST_IDLE);
    assign key_event.valid = out_valid_reg;
    assign key_event.usage_code = out_usage_reg;
    assign key_event.is_press = out_press_reg;
    assign key_event.last_event = out_last_reg;
    assign status.busy = (state_reg != ST_IDLE);
    assign status.step = step_reg;

endmodule

[hw/rtl/hid_boot_report_key_events.sv]
// Top level of the HID boot keyboard report differencer with its register port.
//
// The report channel takes one boot keyboard report: a modifier byte and six key
// slots. Each accepted report is compared with the one stored before it, and the
// key events it causes leave on the key_event channel: changed modifiers first,
// then released keys in old slot order, then pressed keys in new slot order. The
// final event of a report carries last_event; a report that changes nothing
// gives no event at all.
// A report is scanned in 20 steps by one shared compare unit, one step a cycle
// except while the event receiver stalls, then the flush state retires it.
// report.ready stays low from each report until it is retired and is high only
// between reports. Events pass through a one-entry output register; when the
// receiver stalls, the scan waits on that register and nothing is dropped.
// Reset clears the stored report to all zero and loads report_length 8,
// usage_min 4 and usage_max 231. With report_length below 8, reports are taken
// and dropped at once. The user must write the registers over the APB port only
// between reports; the block does not enforce this.
module hid_boot_report_key_events (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hbk_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [hbk_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [hbk_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    hbk_report_if.sink                       report,
    hbk_event_if.source                      key_event
);

    logic [hbk_pkg::LEN_W-1:0]   report_length_reg;
    logic [hbk_pkg::USAGE_W-1:0] usage_min_reg;
    logic [hbk_pkg::USAGE_W-1:0] usage_max_reg;
    hbk_pkg::reg_idx_t           reg_idx;
    logic                        cfg_write;
    hbk_pkg::cfg_t               cfg;
    hbk_pkg::status_t            status;

    assign pready = 1'b1;
    assign reg_idx = hbk_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_length_reg <= hbk_pkg::RESET_REPORT_LENGTH;
            usage_min_reg <= hbk_pkg::RESET_USAGE_MIN;
            usage_max_reg <= hbk_pkg::RESET_USAGE_MAX;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                hbk_pkg::REG_REPORT_LENGTH:
                begin
                    report_length_reg <= pwdata[hbk_pkg::LEN_W-1:0];
                end
                hbk_pkg::REG_USAGE_MIN:
                begin
                    usage_min_reg <= pwdata[hbk_pkg::USAGE_W-1:0];
                end
                hbk_pkg::REG_USAGE_MAX:
                begin
                    usage_max_reg <= pwdata[hbk_pkg::USAGE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            hbk_pkg::REG_REPORT_LENGTH: prdata = hbk_pkg::APB_DATA_W'(report_length_reg);
            hbk_pkg::REG_USAGE_MIN:     prdata = hbk_pkg::APB_DATA_W'(usage_min_reg);
            hbk_pkg::REG_USAGE_MAX:     prdata = hbk_pkg::APB_DATA_W'(usage_max_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.short_report = (report_length_reg < hbk_pkg::MIN_REPORT_BYTES);
    assign cfg.usage_min = usage_min_reg;
    assign cfg.usage_max = usage_max_reg;

    hbk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .report    (report),
        .key_event (key_event),
        .status    (status)
    );

    // A report taken while report_length is below 8 must leave the block idle.
    a_short_drop: assert property (@(posedge clk) disable iff (!rst_n)
        report.valid && report.ready && cfg.short_report |=> !status.busy)
        else $error("short report started a scan");

    // A report taken normally starts its scan at the first step.
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        report.valid && report.ready && !cfg.short_report
        |=> status.busy && (status.step == '0))
        else $error("scan did not start at step zero");

    // The scan step never runs past the last step.
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> status.step < hbk_pkg::STEP_W'(hbk_pkg::STEP_COUNT))
        else $error("scan step out of range");

endmodule
